FILE: hw/rtl/ssol_pkg.sv
package ssol_pkg;

  localparam int MAX_BITS_DEFAULT = 256;

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 8;
  localparam int LENGTH_W = 9;
  localparam int PERIOD_W = 10;

  localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_START = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 10'd2;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_TX,
    PH_STOP
  } phase_t;

  // pin levels for one tick, data bit still to come from the store
  typedef struct packed {
    logic tx;
    logic clock_pin;
    logic latch_pin;
    logic finished;
  } tick_frame_t;

endpackage

FILE: hw/rtl/ssol_if.sv
interface ssol_cmd_if import ssol_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [INDEX_W-1:0]  bit_index;
  logic                bit_value;
  logic [LENGTH_W-1:0] length;

  modport source (output valid, action, bit_index, bit_value, length, input ready);
  modport sink   (input valid, action, bit_index, bit_value, length, output ready);
endinterface

interface ssol_frame_if;
  logic valid;
  logic ready;
  logic data_pin;
  logic clock_pin;
  logic latch_pin;
  logic finished;

  modport source (output valid, data_pin, clock_pin, latch_pin, finished, input ready);
  modport sink   (input valid, data_pin, clock_pin, latch_pin, finished, output ready);
endinterface

FILE: hw/rtl/ssol_ram.sv
module ssol_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/ssol_seq.sv
module ssol_seq import ssol_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEFAULT,
  localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1,
  localparam int CW = $clog2(MAX_BITS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  logic                start,
  input  logic [LENGTH_W-1:0] length,
  input  logic [PERIOD_W-1:0] clock_period,
  output logic [AW-1:0]       rd_addr,
  output tick_frame_t         frame
);

  phase_t              phase, phase_next;
  logic [CW-1:0]       bit_counter, bit_counter_next;
  logic [PERIOD_W-1:0] tick_in_bit, tick_in_bit_next;
  logic [PERIOD_W-1:0] stop_counter, stop_counter_next;
  logic [CW-1:0]       transfer_length, transfer_length_next;

  logic [LENGTH_W-1:0] len_nz;
  logic [CW-1:0]       len_sat;
  logic [CW:0]         bc_inc;
  logic [PERIOD_W:0]   tick_inc;
  logic [PERIOD_W:0]   stop_inc;
  logic [PERIOD_W-1:0] half_period;
  logic [PERIOD_W:0]   stop_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_counter     <= '0;
      tick_in_bit     <= '0;
      stop_counter    <= '0;
      transfer_length <= '0;
    end else begin
      phase           <= phase_next;
      bit_counter     <= bit_counter_next;
      tick_in_bit     <= tick_in_bit_next;
      stop_counter    <= stop_counter_next;
      transfer_length <= transfer_length_next;
    end
  end

  assign rd_addr = bit_counter[AW-1:0];

  always_comb begin
    len_nz = (length == '0) ? LENGTH_W'(1) : length;
    if (32'(len_nz) > MAX_BITS) begin
      len_sat = CW'(MAX_BITS);
    end else begin
      len_sat = CW'(len_nz);
    end
    bc_inc      = {1'b0, bit_counter} + (CW+1)'(1);
    tick_inc    = {1'b0, tick_in_bit} + (PERIOD_W+1)'(1);
    stop_inc    = {1'b0, stop_counter} + (PERIOD_W+1)'(1);
    half_period = clock_period >> 1;
    // ceil of half the period
    stop_len    = ({1'b0, clock_period} + (PERIOD_W+1)'(1)) >> 1;

    phase_next           = phase;
    bit_counter_next     = bit_counter;
    tick_in_bit_next     = tick_in_bit;
    stop_counter_next    = stop_counter;
    transfer_length_next = transfer_length;
    frame                = '0;

    if (start) begin
      transfer_length_next = len_sat;
      phase_next           = PH_START;
      bit_counter_next     = '0;
      tick_in_bit_next     = '0;
      stop_counter_next    = '0;
    end else if (tick) begin
      case (phase)
        PH_START: begin
          frame.latch_pin  = 1'b1;
          bit_counter_next = '0;
          tick_in_bit_next = '0;
          phase_next       = PH_TX;
        end
        PH_TX: begin
          frame.tx         = 1'b1;
          frame.latch_pin  = 1'b1;
          frame.clock_pin  = (tick_in_bit >= half_period);
          tick_in_bit_next = tick_inc[PERIOD_W-1:0];
          if (tick_inc >= {1'b0, clock_period}) begin
            tick_in_bit_next = '0;
            bit_counter_next = bc_inc[CW-1:0];
            if (bc_inc >= {1'b0, transfer_length}) begin
              stop_counter_next = '0;
              phase_next        = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          stop_counter_next = stop_inc[PERIOD_W-1:0];
          if (stop_inc >= stop_len) begin
            frame.finished = 1'b1;
            phase_next     = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/serial_shift_out_latch.sv
// serial_shift_out_latch: drives the data, clock and latch lines of an
// external shift register, one frame of pin levels per tick item.
// cmd channel (valid/ready): action selects tick, load or start. A load item
// writes one bit of the bit store, a start item arms a transfer of length
// bits; neither gives a frame. Each tick item gives exactly one item on the
// frame channel: start tick with latch high, then clock_period ticks per bit
// (clock low for the first half, high for the rest), then a stop phase of
// ceil(clock_period/2) ticks with all lines low, finished high on its last.
// cfg_we/cfg_data write clock_period (values below 2 become 2); the user must
// write it only while no item is in flight, which the block does not enforce.
// A tick item's frame is registered in stage 1 (sequencer frame and bit store
// read) and then in the output register, which drives frame valid.
// Throughput: one item per cycle while the frame receiver does not stall; the
// store read is one registered port addressed by the bit counter.
// Reset: idle, frame valid low, clock_period 2, cmd ready low; the bit store
// is not cleared and bits must be loaded before they are sent.
// When the frame receiver stalls, the pipeline holds its two stages and cmd
// ready drops only once both are full.
module serial_shift_out_latch import ssol_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  ssol_cmd_if.sink            cmd,
  ssol_frame_if.source        frame,
  input  logic                cfg_we,
  input  logic [PERIOD_W-1:0] cfg_data
);

  localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

  logic [PERIOD_W-1:0] clock_period;
  logic                accept;
  logic                tick;
  logic                load;
  logic                start;
  logic                load_ok;
  logic [AW-1:0]       rd_addr;
  logic                rd_data;
  tick_frame_t         seq_frame;
  tick_frame_t         s1_frame;
  logic                s1_valid;
  logic                advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      clock_period <= (cfg_data < PERIOD_MIN) ? PERIOD_MIN : cfg_data;
    end
  end

  // stage 1 moves on whenever the output register is free or being emptied
  assign advance   = !frame.valid || frame.ready;
  assign cmd.ready = !rst && (!s1_valid || advance);
  assign accept    = cmd.valid && cmd.ready;
  assign tick      = accept && (cmd.action == ACT_TICK);
  assign load      = accept && (cmd.action == ACT_LOAD);
  assign start     = accept && (cmd.action == ACT_START);
  assign load_ok   = load && ({24'd0, cmd.bit_index} < 32'(MAX_BITS));

  ssol_seq #(
    .MAX_BITS (MAX_BITS)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .start        (start),
    .length       (cmd.length),
    .clock_period (clock_period),
    .rd_addr      (rd_addr),
    .frame        (seq_frame)
  );

  // read only on a tick so the data holds while stage 1 is stalled
  ssol_ram #(
    .WIDTH (1),
    .DEPTH (MAX_BITS)
  ) u_store (
    .clk   (clk),
    .we    (load_ok),
    .waddr (AW'(32'(cmd.bit_index))),
    .wdata (cmd.bit_value),
    .re    (tick),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_frame <= seq_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (advance) begin
      frame.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      frame.data_pin  <= s1_frame.tx & rd_data;
      frame.clock_pin <= s1_frame.clock_pin;
      frame.latch_pin <= s1_frame.latch_pin;
      frame.finished  <= s1_frame.finished;
    end
  end

endmodule

FILE: tb/tb_serial_shift_out_latch.sv
module tb_serial_shift_out_latch;
  import ssol_pkg::*;

  localparam int MAX_BITS       = MAX_BITS_DEFAULT;
  localparam int TARGET_ITEMS   = 1950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LARGE_PERIOD   = 64;
  localparam int DRAIN_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 8;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic data_pin;
    logic clock_pin;
    logic latch_pin;
    logic finished;
  } pins_t;

  typedef struct packed {
    bit                  cfg_row;
    logic [PERIOD_W-1:0] cfg_val;
    logic [ACTION_W-1:0] act;
    logic [INDEX_W-1:0]  idx;
    logic                val;
    logic [LENGTH_W-1:0] len;
    bit                  typed;
    pins_t               pins;
  } step_t;

  // pins typed in as {data, clock, latch, finished}
  localparam step_t DIRECTED [28] = '{
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b0000},
    '{1'b0, 10'd0, ACT_NONE,  8'd17,  1'b1, 9'd5, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_LOAD,  8'd0,   1'b1, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_LOAD,  8'd1,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_START, 8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b0010},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b1010},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b1110},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b0001},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b0000},
    '{1'b1, 10'd6, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_LOAD,  8'd2,   1'b1, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_LOAD,  8'd255, 1'b1, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_START, 8'd0,   1'b0, 9'd3, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b0010},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    // restart in the middle of a transfer
    '{1'b0, 10'd0, ACT_START, 8'd0,   1'b0, 9'd2, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b0010},
    // bit 1 rewritten before the transmit gets there
    '{1'b0, 10'd0, ACT_LOAD,  8'd1,   1'b1, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    // shorter period while tick_in_bit is already past it
    '{1'b1, 10'd1, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b0, 4'b0000},
    '{1'b0, 10'd0, ACT_TICK,  8'd0,   1'b0, 9'd0, 1'b1, 4'b0001}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we;
  logic [PERIOD_W-1:0] cfg_data;

  ssol_cmd_if   cmd_ch ();
  ssol_frame_if frame_ch ();

  serial_shift_out_latch dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .frame    (frame_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // shifter state as the block should hold it
  phase_t              ph       = PH_IDLE;
  logic [LENGTH_W-1:0] bit_cnt  = '0;
  logic [PERIOD_W-1:0] tib      = '0;
  logic [PERIOD_W-1:0] stop_cnt = '0;
  logic [LENGTH_W-1:0] xfer_len = '0;
  logic [PERIOD_W-1:0] period_r = PERIOD_RESET;
  logic                bit_mem [MAX_BITS];
  bit                  written [MAX_BITS];

  pins_t pins_q [$];
  pins_t want;

  bit steady    = 1'b0;
  bit long_done = 1'b0;
  int err_cnt   = 0;
  int item_cnt  = 0;
  int frame_cnt = 0;
  int fin_cnt   = 0;
  int cfg_cnt   = 0;
  int rx_hold   = 0;
  int rx_stall  = 0;
  int quiet     = 0;

  function automatic bit step_shifter(input logic [ACTION_W-1:0] act,
                                      input logic [INDEX_W-1:0] idx, input logic v,
                                      input logic [LENGTH_W-1:0] len, output pins_t p);
    p = '0;
    case (act)
      ACT_LOAD: begin
        bit_mem[idx] = v;
        written[idx] = 1'b1;
        return 1'b0;
      end
      ACT_START: begin
        if (len == 0) xfer_len = 9'd1;
        else if (len > MAX_BITS) xfer_len = 9'(MAX_BITS);
        else xfer_len = len;
        ph       = PH_START;
        bit_cnt  = '0;
        tib      = '0;
        stop_cnt = '0;
        return 1'b0;
      end
      ACT_TICK: begin
        case (ph)
          PH_START: begin
            p.latch_pin = 1'b1;
            bit_cnt     = '0;
            tib         = '0;
            ph          = PH_TX;
          end
          PH_TX: begin
            p.latch_pin = 1'b1;
            p.data_pin  = (bit_cnt < MAX_BITS) ? bit_mem[bit_cnt[INDEX_W-1:0]] : 1'b0;
            p.clock_pin = (tib >= period_r / 2);
            tib++;
            if (tib >= period_r) begin
              tib = '0;
              bit_cnt++;
              if (bit_cnt >= xfer_len) begin
                stop_cnt = '0;
                ph       = PH_STOP;
              end
            end
          end
          PH_STOP: begin
            stop_cnt++;
            if (int'(stop_cnt) >= (int'(period_r) + 1) / 2) begin
              p.finished = 1'b1;
              ph         = PH_IDLE;
            end
          end
          default: ;
        endcase
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < MAX_BITS && written[n]) n++;
    return n;
  endfunction

  // only lengths whose bits have all been loaded
  function automatic logic [LENGTH_W-1:0] pick_length();
    int pre;
    int r;
    pre = written_prefix();
    r   = $urandom_range(0, 99);
    if (pre == MAX_BITS && period_r <= 3) begin
      if (!long_done) begin
        long_done = 1'b1;
        return 9'($urandom_range(MAX_BITS + 1, 511));
      end
      if (r < 3) return 9'($urandom_range(0, 511));
    end
    if (r < 8) return 9'd0;
    if (r < 20) return 9'($urandom_range(1, pre));
    return 9'($urandom_range(1, pre < 8 ? pre : 8));
  endfunction

  function automatic void check_pin(input string name, input logic exp_v, input logic got);
    if (exp_v !== got) begin
      $error("%s: expected %0b, got %0b", name, exp_v, got);
      err_cnt++;
    end
  endfunction

  task automatic send_cmd(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                          input logic v, input logic [LENGTH_W-1:0] len,
                          input bit typed, input pins_t typed_pins);
    int    gap;
    pins_t p;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= act;
    cmd_ch.bit_index <= idx;
    cmd_ch.bit_value <= v;
    cmd_ch.length    <= len;
    do @(posedge clk); while (!cmd_ch.ready);
    if (step_shifter(act, idx, v, len, p)) begin
      if (typed) p = typed_pins;
      pins_q = {pins_q, p};
    end
    if (act != ACT_NONE) item_cnt++;
  endtask

  task automatic tick_frame();
    send_cmd(ACT_TICK, 8'($urandom), 1'($urandom), 9'($urandom), 1'b0, '0);
  endtask

  task automatic load_bit(input logic [INDEX_W-1:0] idx, input logic v);
    send_cmd(ACT_LOAD, idx, v, 9'($urandom), 1'b0, '0);
  endtask

  task automatic start_xfer(input logic [LENGTH_W-1:0] len);
    send_cmd(ACT_START, 8'($urandom), 1'($urandom), len, 1'b0, '0);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pins_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    period_r = (v < PERIOD_MIN) ? PERIOD_MIN : v;
    cfg_cnt++;
  endtask

  // frame receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        if (pins_q.size() == 0) begin
          $error("frame item arrived with no expectation waiting");
          err_cnt++;
        end else begin
          want = pins_q.pop_front();
          check_pin("data_pin", want.data_pin, frame_ch.data_pin);
          check_pin("clock_pin", want.clock_pin, frame_ch.clock_pin);
          check_pin("latch_pin", want.latch_pin, frame_ch.latch_pin);
          check_pin("finished", want.finished, frame_ch.finished);
          frame_cnt++;
          if (want.finished) fin_cnt++;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        frame_ch.ready <= 1'b0;
      end else begin
        rx_stall = pick_gap();
        if (rx_stall > 0) begin
          rx_hold = rx_stall - 1;
          frame_ch.ready <= 1'b0;
        end else begin
          frame_ch.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb_serial_shift_out_latch: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    step_t               row;
    int                  blk;
    int                  nseq;
    int                  ticks;
    int                  stop_at;
    int                  r;
    int                  pre;
    logic [PERIOD_W-1:0] per;

    cmd_ch.valid     <= 1'b0;
    cmd_ch.action    <= ACT_TICK;
    cmd_ch.bit_index <= '0;
    cmd_ch.bit_value <= 1'b0;
    cmd_ch.length    <= '0;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      if (row.cfg_row) write_period(row.cfg_val);
      else send_cmd(row.act, row.idx, row.val, row.len, row.typed, row.pins);
    end

    blk = 0;
    while (item_cnt < TARGET_ITEMS) begin
      case (blk)
        0: per = 10'd0;
        1: per = 10'd1023;
        2: per = 10'd1;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 65) per = 10'($urandom_range(2, 6));
          else if (r < 82) per = 10'($urandom_range(7, 20));
          else if (r < 95) per = 10'($urandom_range(0, 2));
          else per = 10'($urandom_range(0, 1023));
        end
      endcase
      write_period(per);
      steady <= ($urandom_range(0, 3) == 0);

      if (blk == 3) begin
        for (int i = 0; i < MAX_BITS; i++)
          if (!written[i]) load_bit(8'(i), 1'($urandom));
      end

      nseq = (period_r > LARGE_PERIOD) ? 1 : $urandom_range(1, 4);
      repeat (nseq) begin
        // grow the loaded prefix most of the time, else scatter
        repeat ($urandom_range(0, 5)) begin
          pre = written_prefix();
          if (pre < MAX_BITS && $urandom_range(0, 3) != 0) load_bit(8'(pre), 1'($urandom));
          else load_bit(8'($urandom), 1'($urandom));
        end
        start_xfer(period_r > LARGE_PERIOD ? 9'd1 : pick_length());
        stop_at = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 6) : -1;
        ticks   = 0;
        do begin
          r = $urandom_range(0, 99);
          if (r < 4) send_cmd(ACT_NONE, 8'($urandom), 1'($urandom), 9'($urandom), 1'b0, '0);
          else if (r < 8) load_bit(8'($urandom), 1'($urandom));
          else if (r < 10 && period_r <= LARGE_PERIOD) start_xfer(pick_length());
          tick_frame();
          ticks++;
          // long bits: once the clock has gone high, cut the period short
          if (period_r > LARGE_PERIOD && ticks == int'(period_r) / 2 + 20)
            write_period(10'($urandom_range(2, 6)));
        end while (ph != PH_IDLE && ticks != stop_at);
      end
      blk++;
    end

    cmd_ch.valid <= 1'b0;
    while (pins_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d cmd items in %0d period settings, %0d frames checked",
             item_cnt, cfg_cnt, frame_cnt);
    $display("%0d transfers ran to the finished pulse", fin_cnt);
    if (err_cnt == 0) begin
      $display("tb_serial_shift_out_latch: clean");
    end else begin
      $display("tb_serial_shift_out_latch: errors");
    end
    $finish;
  end

endmodule
